// File: src/jtl_pkg.sv
// shared types, codes and byte-class functions for the json token lexer
package jtl_pkg;

  // token class codes on the result word
  localparam logic [2:0] CLS_EOS    = 3'd0;
  localparam logic [2:0] CLS_PUNCT  = 3'd1;
  localparam logic [2:0] CLS_NUMBER = 3'd2;
  localparam logic [2:0] CLS_STRING = 3'd3;
  localparam logic [2:0] CLS_BARE   = 3'd4;

  // result queue geometry (depth is a power of two so pointers wrap)
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // one result word
  typedef struct packed {
    logic [2:0] token_class;
    logic       char_valid;
    logic [7:0] char_value;
    logic       token_end;
    logic       last_result;
  } result_t;

  function automatic logic is_punct(input logic [7:0] b);
    return b == 8'h5B || b == 8'h5D || b == 8'h7B || b == 8'h7D || b == 8'h3A;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_number_byte(input logic [7:0] b);
    return is_digit(b) || b == 8'h2D || b == 8'h2B || b == 8'h2E
           || b == 8'h65 || b == 8'h45;
  endfunction

  function automatic logic is_bare_byte(input logic [7:0] b);
    return b > 8'd32 && !is_punct(b) && b != 8'h2C && b != 8'h22;
  endfunction

  // string escapes b f n r t, anything else passes through
  function automatic logic [7:0] map_escape(input logic [7:0] b);
    logic [7:0] m;
    unique case (b)
      8'h62:   m = 8'd8;
      8'h66:   m = 8'd12;
      8'h6E:   m = 8'd10;
      8'h72:   m = 8'd13;
      8'h74:   m = 8'd9;
      default: m = b;
    endcase
    return m;
  endfunction

  function automatic result_t make_result(input logic [2:0] cls, input logic valid,
                                          input logic [7:0] val, input logic end_flag);
    result_t r;
    r.token_class = cls;
    r.char_valid  = valid;
    r.char_value  = valid ? val : 8'd0;
    r.token_end   = end_flag;
    r.last_result = 1'b0;
    return r;
  endfunction

endpackage

// File: src/jtl_decode.sv
// lexer mode register and per-byte decode into up to two result words
module jtl_decode import jtl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_value,
  input  logic       end_of_input,
  output result_t    res [2],
  output logic [1:0] res_n
);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_NUMBER = 3'd1;
  localparam logic [2:0] MODE_STRING = 3'd2;
  localparam logic [2:0] MODE_ESCAPE = 3'd3;
  localparam logic [2:0] MODE_BARE   = 3'd4;

  logic [2:0] mode;
  logic [2:0] mode_next;

  // token start as seen from idle
  result_t    st_res;
  logic       st_has;
  logic [2:0] st_mode;

  always_comb begin
    st_res  = make_result(CLS_BARE, 1'b1, byte_value, 1'b0);
    st_has  = 1'b1;
    st_mode = MODE_BARE;
    priority if (byte_value <= 8'd32 || byte_value == 8'h2C) begin
      st_has  = 1'b0;
      st_mode = MODE_IDLE;
    end else if (is_punct(byte_value)) begin
      st_res  = make_result(CLS_PUNCT, 1'b1, byte_value, 1'b1);
      st_mode = MODE_IDLE;
    end else if (byte_value == 8'h2D || is_digit(byte_value)) begin
      st_res  = make_result(CLS_NUMBER, 1'b1, byte_value, 1'b0);
      st_mode = MODE_NUMBER;
    end else if (byte_value == 8'h22) begin
      st_has  = 1'b0;
      st_mode = MODE_STRING;
    end else begin
      st_mode = MODE_BARE;
    end
  end

  // main decode
  always_comb begin
    res[0]    = make_result(CLS_EOS, 1'b0, 8'd0, 1'b0);
    res[1]    = make_result(CLS_EOS, 1'b0, 8'd0, 1'b0);
    res_n     = 2'd0;
    mode_next = mode;
    if (end_of_input) begin
      mode_next = MODE_IDLE;
      unique case (mode)
        MODE_NUMBER: begin
          res[0] = make_result(CLS_NUMBER, 1'b0, 8'd0, 1'b1);
          res_n  = 2'd2;
        end
        MODE_STRING, MODE_ESCAPE: begin
          res[0] = make_result(CLS_STRING, 1'b0, 8'd0, 1'b1);
          res_n  = 2'd2;
        end
        MODE_BARE: begin
          res[0] = make_result(CLS_BARE, 1'b0, 8'd0, 1'b1);
          res_n  = 2'd2;
        end
        default: res_n = 2'd1;
      endcase
      // end of stream word sits right after any closing marker
      if (res_n == 2'd1) res[0] = make_result(CLS_EOS, 1'b0, 8'd0, 1'b0);
    end else begin
      unique case (mode)
        MODE_NUMBER: begin
          if (byte_value != 8'd0 && is_number_byte(byte_value)) begin
            res[0] = make_result(CLS_NUMBER, 1'b1, byte_value, 1'b0);
            res_n  = 2'd1;
          end else begin
            res[0]    = make_result(CLS_NUMBER, 1'b0, 8'd0, 1'b1);
            res[1]    = st_res;
            res_n     = st_has ? 2'd2 : 2'd1;
            mode_next = st_mode;
          end
        end
        MODE_STRING: begin
          priority if (byte_value == 8'h22) begin
            res[0]    = make_result(CLS_STRING, 1'b0, 8'd0, 1'b1);
            res_n     = 2'd1;
            mode_next = MODE_IDLE;
          end else if (byte_value == 8'h5C) begin
            mode_next = MODE_ESCAPE;
          end else begin
            res[0] = make_result(CLS_STRING, 1'b1, byte_value, 1'b0);
            res_n  = 2'd1;
          end
        end
        MODE_ESCAPE: begin
          res[0]    = make_result(CLS_STRING, 1'b1, map_escape(byte_value), 1'b0);
          res_n     = 2'd1;
          mode_next = MODE_STRING;
        end
        MODE_BARE: begin
          if (is_bare_byte(byte_value)) begin
            res[0] = make_result(CLS_BARE, 1'b1, byte_value, 1'b0);
            res_n  = 2'd1;
          end else begin
            res[0]    = make_result(CLS_BARE, 1'b0, 8'd0, 1'b1);
            res[1]    = st_res;
            res_n     = st_has ? 2'd2 : 2'd1;
            mode_next = st_mode;
          end
        end
        default: begin
          res[0]    = st_res;
          res_n     = st_has ? 2'd1 : 2'd0;
          mode_next = st_mode;
        end
      endcase
    end
    // flag the final word of this byte
    if (res_n == 2'd1) res[0].last_result = 1'b1;
    if (res_n == 2'd2) res[1].last_result = 1'b1;
  end

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule

// File: src/jtl_outq.sv
// small result queue: up to two words in per cycle, one word out while the output is not stalled
module jtl_outq import jtl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  result_t    push_data [2],
  output logic       full,
  output logic       out_valid,
  input  logic       out_stall,
  output result_t    out_data
);

  result_t             entries [QDEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QCNT_W-1:0]   count;
  logic                pop;

  // room for two words is needed before a byte is taken
  assign full      = count > QCNT_W'(QDEPTH - 2);
  assign out_valid = count != '0;
  assign out_data  = entries[rptr];
  assign pop       = out_valid && !out_stall;

  // payload writes
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) entries[wptr] <= push_data[0];
    if (push_n == 2'd2) entries[wptr + QPTR_W'(1)] <= push_data[1];
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QPTR_W'(push_n);
      if (pop) rptr <= rptr + QPTR_W'(1);
      count <= count + QCNT_W'(push_n) - QCNT_W'(pop);
    end
  end

endmodule

// File: src/json_token_lexer.sv
// top level of the streaming json token lexer
// One byte (or end-of-input mark) is taken per cycle. Each byte yields zero, one
// or two result words; a byte that closes a number or bare word and also emits
// a word of its own, and an end of input inside a token, give two words. The
// result port moves one word per cycle through a four-word queue, so the
// sustained input rate is one byte per cycle while each byte gives at most one
// word and the output does not stall; runs where each byte gives two stall the
// input. A byte is taken while at least two queue slots are free. No memory
// clearing is needed after reset; the lexer starts idle between tokens.
module json_token_lexer import jtl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_value,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] token_class,
  output logic       char_valid,
  output logic [7:0] char_value,
  output logic       token_end,
  output logic       last_result
);

  logic       accept;
  logic       full;
  result_t    res [2];
  logic [1:0] res_n;
  logic [1:0] push_n;
  result_t    head;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign push_n   = accept ? res_n : 2'd0;

  // byte decode and mode
  jtl_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .byte_value   (byte_value),
    .end_of_input (end_of_input),
    .res          (res),
    .res_n        (res_n)
  );

  // result queue
  jtl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head)
  );

  assign token_class = head.token_class;
  assign char_valid  = head.char_valid;
  assign char_value  = head.char_value;
  assign token_end   = head.token_end;
  assign last_result = head.last_result;

endmodule

// File: src/jtl_checker.sv
// port-level checks for the json token lexer, bound to the top level
module jtl_checker import jtl_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] token_class,
  input logic       char_valid,
  input logic [7:0] char_value,
  input logic       token_end,
  input logic       last_result
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_class) && $stable(char_valid)
      && $stable(char_value) && $stable(token_end) && $stable(last_result))
    else $error("stalled result word changed");

  // results only appear after a byte was taken
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result word appeared without an accepted byte");

  // the queue only fills up on an accepted byte
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stall rose without an accepted byte");

  // end of stream word is always the last and carries no byte
  a_eos_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_class == CLS_EOS |-> last_result && !char_valid && !token_end)
    else $error("malformed end of stream word");

endmodule

bind json_token_lexer jtl_checker u_jtl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .token_class (token_class),
  .char_valid  (char_valid),
  .char_value  (char_value),
  .token_end   (token_end),
  .last_result (last_result)
);
